// ===== rtl/mvm_pkg.sv =====
// Shared constants, types and helpers for the matrix-vector multiply block.
package mvm_pkg;

    localparam int MAX_DIM = 16;
    localparam int RowW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DimW    = 5;
    localparam int ValW    = 16;
    localparam int ProdW   = 2 * ValW;
    localparam int DotW    = 36;
    localparam int IdxW    = 4;
    localparam int ResRowW = 4;
    localparam int CmdW    = 2;
    localparam int CfgIdxW = 2;

    localparam logic signed [DotW-1:0] DOT_MAX = {1'b0, {(DotW-1){1'b1}}};
    localparam logic signed [DotW-1:0] DOT_MIN = {1'b1, {(DotW-1){1'b0}}};

    typedef enum logic [CmdW-1:0] {
        CMD_LOAD_MAT = 2'd0,
        CMD_LOAD_VEC = 2'd1,
        CMD_MULT     = 2'd2
    } cmd_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_VLEN = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    // Control that travels with one row through the chain
    typedef struct packed {
        logic            valid;
        logic [RowW-1:0] row;
        logic            last;
        logic            mismatch;
    } tok_t;

    // Per-cell load and column control from the top level
    typedef struct packed {
        logic            mat_we;
        logic            vec_we;
        logic            active;
        logic [RowW-1:0] wr_row;
    } cell_ctl_t;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
        logic [DimW-1:0] r;
        if (v == '0)
            r = DimW'(1);
        else if (int'(v) > MAX_DIM)
            r = DimW'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/mvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mvm_cell.sv =====
// One chain cell: holds one matrix column and one vector element, adds its product.
module mvm_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  mvm_pkg::cell_ctl_t                  ctl,
    input  logic [mvm_pkg::ValW-1:0]            wr_data,
    input  mvm_pkg::tok_t                       in_tok,
    input  logic signed [mvm_pkg::DotW-1:0]     in_sum,
    output mvm_pkg::tok_t                       out_tok,
    output logic signed [mvm_pkg::DotW-1:0]     out_sum,
    output logic                                busy
);

    logic [mvm_pkg::ValW-1:0]         vec_reg;
    logic [mvm_pkg::ValW-1:0]         m_data;
    mvm_pkg::tok_t                    a_tok_reg;
    logic signed [mvm_pkg::DotW-1:0]  a_sum_reg;
    mvm_pkg::tok_t                    out_tok_reg;
    logic signed [mvm_pkg::DotW-1:0]  out_sum_reg;
    logic signed [mvm_pkg::ProdW-1:0] prod;
    logic signed [mvm_pkg::DotW:0]    sum_wide;
    logic signed [mvm_pkg::DotW-1:0]  sum_sat;
    logic signed [mvm_pkg::DotW-1:0]  out_sum_next;
    logic                             add_en;

    mvm_ram #(
        .WIDTH(mvm_pkg::ValW),
        .DEPTH(mvm_pkg::MAX_DIM)
    ) u_col (
        .clk  (clk),
        .we   (ctl.mat_we),
        .waddr(ctl.wr_row),
        .wdata(wr_data),
        .re   (advance),
        .raddr(in_tok.row),
        .rdata(m_data)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.vec_we)
        begin
            vec_reg <= wr_data;
        end
    end

    always_comb
    begin
        prod     = $signed(m_data) * $signed(vec_reg);
        sum_wide = $signed({a_sum_reg[mvm_pkg::DotW-1], a_sum_reg})
                 + (mvm_pkg::DotW + 1)'(prod);
        // saturate to the signed result range
        if (sum_wide[mvm_pkg::DotW] != sum_wide[mvm_pkg::DotW-1])
            sum_sat = sum_wide[mvm_pkg::DotW] ? mvm_pkg::DOT_MIN : mvm_pkg::DOT_MAX;
        else
            sum_sat = sum_wide[mvm_pkg::DotW-1:0];
        add_en       = a_tok_reg.valid && ctl.active && !a_tok_reg.mismatch;
        out_sum_next = add_en ? sum_sat : a_sum_reg;
    end

    // Stage A waits on the column read, stage B holds the updated sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tok_reg   <= '0;
            out_tok_reg <= '0;
        end
        else if (advance)
        begin
            a_tok_reg   <= in_tok;
            out_tok_reg <= a_tok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_sum_reg   <= in_sum;
            out_sum_reg <= out_sum_next;
        end
    end

    assign out_tok = out_tok_reg;
    assign out_sum = out_sum_reg;
    assign busy    = a_tok_reg.valid || out_tok_reg.valid;

endmodule

// ===== rtl/matrix_vector_multiply.sv =====
// Top level: command decode, row sequencer, cell chain and output register.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------------------
//   in       | in        | in_valid / in_stall | command, row_index, col_index, entry_value
//   out      | out       | out_valid/out_stall | result_row, dot_product, size_mismatch, last
//   cfg      | in        | cfg_write           | cfg_index, cfg_data
//
// Load items are taken back to back while no multiply is in progress.
// A multiply issues one row per cycle, unless out_stall holds the chain, into a chain of
// MAX_DIM cells of two stages each; the next item is taken only once no row is left in
// the chain (on a size mismatch only one row is issued). out_stall freezes the whole
// chain while out_valid is high; the output register lets the next input transfer
// happen while the final result still waits. Reset clears control state only.
module matrix_vector_multiply (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [mvm_pkg::CmdW-1:0]              command,
    input  logic [mvm_pkg::IdxW-1:0]              row_index,
    input  logic [mvm_pkg::IdxW-1:0]              col_index,
    input  logic signed [mvm_pkg::ValW-1:0]       entry_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [mvm_pkg::ResRowW-1:0]           result_row,
    output logic signed [mvm_pkg::DotW-1:0]       dot_product,
    output logic                                  size_mismatch,
    output logic                                  last,
    input  logic                                  cfg_write,
    input  logic [mvm_pkg::CfgIdxW-1:0]           cfg_index,
    input  logic [mvm_pkg::DimW-1:0]              cfg_data
);

    logic [mvm_pkg::DimW-1:0]        row_count_reg;
    logic [mvm_pkg::DimW-1:0]        col_count_reg;
    logic [mvm_pkg::DimW-1:0]        vec_len_reg;

    mvm_pkg::state_t                 state_reg, state_next;
    logic [mvm_pkg::RowW-1:0]        row_cnt_reg, row_cnt_next;
    logic                            mismatch_reg, mismatch_next;

    logic                            accept;
    logic                            advance;
    logic                            mat_load_ok;
    logic                            vec_load_ok;
    logic                            chain_busy;

    mvm_pkg::tok_t                   chain_tok [mvm_pkg::MAX_DIM+1];
    logic signed [mvm_pkg::DotW-1:0] chain_sum [mvm_pkg::MAX_DIM+1];
    mvm_pkg::cell_ctl_t              cell_ctl  [mvm_pkg::MAX_DIM];
    logic [mvm_pkg::MAX_DIM-1:0]     cell_busy;

    logic                            out_valid_reg;
    logic [mvm_pkg::ResRowW-1:0]     out_row_reg;
    logic signed [mvm_pkg::DotW-1:0] out_dot_reg;
    logic                            out_mis_reg;
    logic                            out_last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= mvm_pkg::DimW'(1);
            col_count_reg <= mvm_pkg::DimW'(1);
            vec_len_reg   <= mvm_pkg::DimW'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mvm_pkg::REG_ROWS: row_count_reg <= mvm_pkg::clamp_dim(cfg_data);
                mvm_pkg::REG_COLS: col_count_reg <= mvm_pkg::clamp_dim(cfg_data);
                mvm_pkg::REG_VLEN: vec_len_reg   <= mvm_pkg::clamp_dim(cfg_data);
                default: ;
            endcase
        end
    end

    assign in_stall    = (state_reg != mvm_pkg::S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign advance     = !out_valid_reg || !out_stall;
    assign mat_load_ok = accept && (command == mvm_pkg::CMD_LOAD_MAT)
                       && (int'(row_index) < mvm_pkg::MAX_DIM);
    assign vec_load_ok = accept && (command == mvm_pkg::CMD_LOAD_VEC);
    assign chain_busy  = |cell_busy;

    // Head of the chain: one row token per cycle while issuing and the chain advances
    always_comb
    begin
        chain_tok[0].valid    = (state_reg == mvm_pkg::S_ISSUE);
        chain_tok[0].row      = row_cnt_reg;
        chain_tok[0].mismatch = mismatch_reg;
        chain_tok[0].last     = mismatch_reg
                              || (int'(row_cnt_reg) + 1 == int'(row_count_reg));
        chain_sum[0]          = '0;
    end

    for (genvar j = 0; j < mvm_pkg::MAX_DIM; j++)
    begin : g_cell
        always_comb
        begin
            cell_ctl[j].mat_we = mat_load_ok && (int'(col_index) == j);
            cell_ctl[j].vec_we = vec_load_ok && (int'(col_index) == j);
            cell_ctl[j].active = (j < int'(col_count_reg));
            cell_ctl[j].wr_row = mvm_pkg::RowW'(row_index);
        end

        mvm_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .advance(advance),
            .ctl    (cell_ctl[j]),
            .wr_data(entry_value),
            .in_tok (chain_tok[j]),
            .in_sum (chain_sum[j]),
            .out_tok(chain_tok[j+1]),
            .out_sum(chain_sum[j+1]),
            .busy   (cell_busy[j])
        );
    end

    // Row sequencer
    always_comb
    begin
        state_next    = state_reg;
        row_cnt_next  = row_cnt_reg;
        mismatch_next = mismatch_reg;
        unique case (state_reg)
            mvm_pkg::S_IDLE:
            begin
                if (accept && (command == mvm_pkg::CMD_MULT))
                begin
                    mismatch_next = (col_count_reg != vec_len_reg);
                    row_cnt_next  = '0;
                    state_next    = mvm_pkg::S_ISSUE;
                end
            end
            mvm_pkg::S_ISSUE:
            begin
                if (advance)
                begin
                    if (chain_tok[0].last)
                        state_next = mvm_pkg::S_DRAIN;
                    else
                        row_cnt_next = row_cnt_reg + 1'b1;
                end
            end
            mvm_pkg::S_DRAIN:
            begin
                // hold off new items until no row is left in the chain
                if (!chain_busy)
                    state_next = mvm_pkg::S_IDLE;
            end
            default: state_next = mvm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mvm_pkg::S_IDLE;
            row_cnt_reg  <= '0;
            mismatch_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_cnt_reg  <= row_cnt_next;
            mismatch_reg <= mismatch_next;
        end
    end

    // Output register at the tail of the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_tok[mvm_pkg::MAX_DIM].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_row_reg  <= mvm_pkg::ResRowW'(chain_tok[mvm_pkg::MAX_DIM].row);
            out_dot_reg  <= chain_sum[mvm_pkg::MAX_DIM];
            out_mis_reg  <= chain_tok[mvm_pkg::MAX_DIM].mismatch;
            out_last_reg <= chain_tok[mvm_pkg::MAX_DIM].last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_row    = out_row_reg;
    assign dot_product   = out_dot_reg;
    assign size_mismatch = out_mis_reg;
    assign last          = out_last_reg;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        chain_busy |-> in_stall)
        else $error("input taken while rows are in the chain");

    a_mismatch_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && size_mismatch) |-> last)
        else $error("size mismatch result not flagged last");

    a_mismatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && size_mismatch) |-> (result_row == '0 && dot_product == '0))
        else $error("size mismatch result carries data");

    a_issue_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mvm_pkg::S_ISSUE && advance && chain_tok[0].last)
            |=> (state_reg == mvm_pkg::S_DRAIN))
        else $error("sequencer kept issuing after the last row");

endmodule

// ===== tb/tb_matrix_vector_multiply.sv =====
// Self-checking testbench for the matrix-vector multiply block.
module tb_matrix_vector_multiply;

    import mvm_pkg::*;

    localparam int DRAIN_CYCLES = 2 * MAX_DIM + 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEM_TARGET  = 410;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CmdW-1:0]    CMD_UNUSED = 2'd3;
    localparam logic [CfgIdxW-1:0] REG_NONE   = 2'd3;

    typedef struct {
        logic [ResRowW-1:0]     row;
        logic signed [DotW-1:0] dot;
        logic                   mismatch;
        logic                   last;
    } row_result_t;

    class mvm_scoreboard;
        logic signed [ValW-1:0] matrix [MAX_DIM][MAX_DIM];
        logic signed [ValW-1:0] vector [MAX_DIM];
        logic [DimW-1:0]        rows;
        logic [DimW-1:0]        cols;
        logic [DimW-1:0]        vlen;
        row_result_t            expected_rows[$];
        int                     errors;

        function new();
            rows   = DimW'(1);
            cols   = DimW'(1);
            vlen   = DimW'(1);
            errors = 0;
        endfunction

        function logic [DimW-1:0] fit_dim(logic [DimW-1:0] raw);
            if (raw == '0)
                return DimW'(1);
            if (int'(raw) > MAX_DIM)
                return DimW'(MAX_DIM);
            return raw;
        endfunction

        function void set_dim(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] raw);
            case (idx)
                REG_ROWS: rows = fit_dim(raw);
                REG_COLS: cols = fit_dim(raw);
                REG_VLEN: vlen = fit_dim(raw);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        // Apply one accepted command and queue the row products it produces.
        function void take_command(logic [CmdW-1:0] cmd, logic [IdxW-1:0] r,
                                   logic [IdxW-1:0] c, logic signed [ValW-1:0] v);
            longint      acc;
            row_result_t res;
            int          i;
            int          j;
            case (cmd)
                CMD_LOAD_MAT: matrix[r][c] = v;
                CMD_LOAD_VEC: vector[c] = v;
                CMD_MULT:
                begin
                    if (cols != vlen)
                    begin
                        res.row      = '0;
                        res.dot      = '0;
                        res.mismatch = 1'b1;
                        res.last     = 1'b1;
                        expected_rows.push_back(res);
                    end
                    else
                    begin
                        for (i = 0; i < int'(rows); i++)
                        begin
                            acc = 0;
                            for (j = 0; j < int'(cols); j++)
                            begin
                                acc += longint'(matrix[i][j]) * longint'(vector[j]);
                                if (acc > DOT_MAX)
                                    acc = DOT_MAX;
                                else if (acc < DOT_MIN)
                                    acc = DOT_MIN;
                            end
                            res.row      = i[ResRowW-1:0];
                            res.dot      = acc[DotW-1:0];
                            res.mismatch = 1'b0;
                            res.last     = (i + 1 == int'(rows));
                            expected_rows.push_back(res);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic signed [DotW-1:0] want,
                                    logic signed [DotW-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(row_result_t got);
            row_result_t want;
            if (expected_rows.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none actual row %0d dot %0d",
                         $time, got.row, got.dot);
                return;
            end
            want = expected_rows.pop_front();
            compare_field("result_row", DotW'(want.row), DotW'(got.row));
            compare_field("dot_product", want.dot, got.dot);
            compare_field("size_mismatch", DotW'(want.mismatch), DotW'(got.mismatch));
            compare_field("last", DotW'(want.last), DotW'(got.last));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [CmdW-1:0]        command;
    logic [IdxW-1:0]        row_index;
    logic [IdxW-1:0]        col_index;
    logic signed [ValW-1:0] entry_value;
    logic                   out_valid;
    logic                   out_stall;
    logic [ResRowW-1:0]     result_row;
    logic signed [DotW-1:0] dot_product;
    logic                   size_mismatch;
    logic                   last;
    logic                   cfg_write;
    logic [CfgIdxW-1:0]     cfg_index;
    logic [DimW-1:0]        cfg_data;

    mvm_scoreboard sb;
    bit            mat_written [MAX_DIM][MAX_DIM];
    bit            vec_written [MAX_DIM];
    bit            calm;
    bit            hold_req;
    int            items_sent;
    int            cycles;

    matrix_vector_multiply u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .row_index     (row_index),
        .col_index     (col_index),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_row    (result_row),
        .dot_product   (dot_product),
        .size_mismatch (size_mismatch),
        .last          (last),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall <= !calm && ($urandom_range(99) < 23);
        end
    end

    always @(posedge clk)
    begin
        row_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.row      = result_row;
            got.dot      = dot_product;
            got.mismatch = size_mismatch;
            got.last     = last;
            sb.check_result(got);
        end
    end

    function automatic logic [ValW-1:0] rand_q88();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return ValW'($urandom);
        endcase
    endfunction

    // Register data for a dimension, sometimes in an out-of-range encoding.
    function automatic logic [DimW-1:0] dim_code(int d);
        if (d == 1 && $urandom_range(3) == 0)
            return '0;
        if (d == MAX_DIM && $urandom_range(1) == 0)
            return DimW'($urandom_range(MAX_DIM + 1, 31));
        return DimW'(d);
    endfunction

    task automatic send_item(input logic [CmdW-1:0] cmd, input logic [IdxW-1:0] r,
                             input logic [IdxW-1:0] c, input logic [ValW-1:0] v);
        while (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        row_index   <= r;
        col_index   <= c;
        entry_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_command(cmd, r, c, v);
        if (cmd == CMD_LOAD_MAT)
            mat_written[r][c] = 1'b1;
        if (cmd == CMD_LOAD_VEC)
            vec_written[c] = 1'b1;
        if (cmd != CMD_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Hold the input side until every result is in and the chain has emptied.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_dim(idx, data);
        @(negedge clk);
    endtask

    task automatic write_dims(input logic [DimW-1:0] r, input logic [DimW-1:0] c,
                              input logic [DimW-1:0] v);
        write_reg(REG_ROWS, r);
        write_reg(REG_COLS, c);
        write_reg(REG_VLEN, v);
        cfg_write <= 1'b0;
    endtask

    task automatic load_region();
        int r;
        int c;
        for (r = 0; r < int'(sb.rows); r++)
            for (c = 0; c < int'(sb.cols); c++)
                send_item(CMD_LOAD_MAT, IdxW'(r), IdxW'(c), rand_q88());
        for (c = 0; c < int'(sb.cols); c++)
            send_item(CMD_LOAD_VEC, IdxW'($urandom), IdxW'(c), rand_q88());
    endtask

    // Fill any entry the multiply would read that was never written, then multiply.
    task automatic issue_multiply();
        int r;
        int c;
        if (sb.cols == sb.vlen)
        begin
            for (r = 0; r < int'(sb.rows); r++)
                for (c = 0; c < int'(sb.cols); c++)
                    if (!mat_written[r][c])
                        send_item(CMD_LOAD_MAT, IdxW'(r), IdxW'(c), rand_q88());
            for (c = 0; c < int'(sb.cols); c++)
                if (!vec_written[c])
                    send_item(CMD_LOAD_VEC, IdxW'($urandom), IdxW'(c), rand_q88());
        end
        send_item(CMD_MULT, IdxW'($urandom), IdxW'($urandom), ValW'($urandom));
    endtask

    task automatic well_formed();
        if (int'(sb.rows) * int'(sb.cols) <= 16)
            load_region();
        else
            repeat (4)
                send_item(CMD_LOAD_MAT, IdxW'($urandom_range(int'(sb.rows) - 1)),
                          IdxW'($urandom_range(int'(sb.cols) - 1)), rand_q88());
        repeat ($urandom_range(1, 2))
            issue_multiply();
    endtask

    task automatic noise();
        case ($urandom_range(2))
            0: send_item(CmdW'($urandom_range(1)), IdxW'($urandom), IdxW'($urandom),
                         rand_q88());
            1: send_item(CMD_UNUSED, IdxW'($urandom), IdxW'($urandom), ValW'($urandom));
            default: issue_multiply();
        endcase
    endtask

    initial
    begin
        int phase;
        int nr;
        int nc;
        int nv;
        sb          = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        items_sent  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = '0;
        row_index   = '0;
        col_index   = '0;
        entry_value = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extreme products, ignored command, mismatch, last flag.
        write_dims(5'd1, 5'd1, 5'd1);
        send_item(CMD_LOAD_MAT, 4'd0, 4'd0, 16'h8000);
        send_item(CMD_LOAD_VEC, 4'd15, 4'd0, 16'h8000);
        send_item(CMD_MULT, 4'd0, 4'd0, 16'h0000);
        send_item(CMD_LOAD_MAT, 4'd0, 4'd0, 16'h7fff);
        send_item(CMD_MULT, 4'd15, 4'd15, 16'hffff);
        send_item(CMD_LOAD_VEC, 4'd0, 4'd0, 16'h7fff);
        send_item(CMD_MULT, 4'd0, 4'd0, 16'h0000);
        send_item(CMD_LOAD_MAT, 4'd15, 4'd15, 16'hffff);
        send_item(CMD_LOAD_VEC, 4'd15, 4'd15, 16'h5a5a);
        send_item(CMD_UNUSED, 4'd15, 4'd15, 16'hffff);
        wait_idle();
        write_reg(REG_NONE, 5'd31);
        write_dims(5'd0, 5'd2, 5'd1);
        send_item(CMD_MULT, 4'd0, 4'd0, 16'h0000);
        wait_idle();
        write_dims(5'd2, 5'd2, 5'd2);
        load_region();
        issue_multiply();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            calm = (phase == 2);
            nr = $urandom_range(1, 4);
            nc = $urandom_range(1, 4);
            nv = nc;
            if (phase == 4)
            begin
                nr = 8;
                nc = 3;
                nv = 3;
            end
            else
            begin
                case ($urandom_range(9))
                    0:
                    begin
                        nr = MAX_DIM;
                        nc = $urandom_range(1, 3);
                        nv = nc;
                    end
                    1:
                    begin
                        nc = MAX_DIM;
                        nv = MAX_DIM;
                    end
                    2:
                    begin
                        nc = $urandom_range(1, MAX_DIM);
                        nv = (nc % MAX_DIM) + $urandom_range(1, MAX_DIM - 1);
                        if (nv > MAX_DIM)
                            nv -= MAX_DIM;
                    end
                    default: ;
                endcase
            end
            write_dims(dim_code(nr), dim_code(nc), dim_code(nv));
            if (phase == 4)
            begin
                // Block the result side while multiplies keep coming.
                hold_req = 1'b1;
                load_region();
                repeat (6)
                    issue_multiply();
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    if ($urandom_range(3) != 0)
                        well_formed();
                    else
                        noise();
            end
            phase++;
        end
        calm = 1'b0;
        wait_idle();

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mvm_pkg.sv
rtl/mvm_ram.sv
rtl/mvm_cell.sv
rtl/matrix_vector_multiply.sv
tb/tb_matrix_vector_multiply.sv
